// ----- design/dvre_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package dvre_pkg;
  localparam int NODES = 8;
  localparam int IDW = 4;
  localparam int NW = $clog2(NODES);
  localparam int CW = 16;
  localparam logic [CW-1:0] INF_COST = 16'hFFFF;
  localparam logic [2:0] DEAD_COUNT = 3'd4;
  localparam logic [2:0] COUNT_MAX = 3'd7;
  localparam int VDEPTH = NODES * NODES;
  localparam int VAW = $clog2(VDEPTH);

  localparam logic [1:0] OP_ENTRY = 2'd0;
  localparam logic [1:0] OP_COST = 2'd1;
  localparam logic [1:0] OP_DISABLE = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  localparam logic CFG_SELF_ID = 1'b0;
  localparam logic CFG_MASK = 1'b1;

  typedef struct packed {
    logic [1:0] operation;
    logic [IDW-1:0] node_id;
    logic [IDW-1:0] dest_id;
    logic [CW-1:0] cost;
    logic last;
  } in_item_t;

  typedef struct packed {
    logic status;
    logic [IDW-1:0] dest_id_res;
    logic [CW-1:0] route_cost;
    logic [IDW-1:0] next_hop;
    logic last_res;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;      // capture the input beat
    logic apply_item;     // update state for op 0/1/2 if valid
    logic tick_step;      // age neighbour at sweep index
    logic clr_best;       // start a new destination
    logic eval;           // compare one neighbour
    logic emit;           // load output register from current destination
    logic emit_status;    // load output register with status-only result
    logic [NW-1:0] q;     // neighbour index
    logic [NW-1:0] d;     // destination index
  } dp_cmd_t;

  typedef struct packed {
    logic item_ok;        // target active and, for an entry, dest in range
    logic [1:0] operation;
    logic last;
  } dp_stat_t;
endpackage
`default_nettype wire

// ----- design/dvre_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dvre_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic out_full,
  input  wire logic out_take,
  input  wire dvre_pkg::dp_stat_t stat,
  output dvre_pkg::dp_cmd_t cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_TICK = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_LAT = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;
  localparam logic [2:0] S_STATUS = 3'd6;

  logic [2:0] state, state_next;
  logic [dvre_pkg::NW-1:0] q, q_next, d, d_next;
  logic room;

  assign room = !out_full || out_take;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    q_next = q;
    d_next = d;
    cmd = '0;
    cmd.q = q;
    cmd.d = d;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        q_next = '0;
        d_next = '0;
        if (stat.operation == dvre_pkg::OP_TICK) begin
          state_next = S_TICK;
        end else begin
          cmd.apply_item = 1'b1;
          if (stat.item_ok && (stat.operation == dvre_pkg::OP_COST ||
              (stat.operation == dvre_pkg::OP_ENTRY && stat.last)))
            state_next = S_LAT;
          else
            state_next = S_STATUS;
        end
      end
      S_TICK: begin
        cmd.tick_step = 1'b1;
        q_next = q + 1'b1;
        if (q == dvre_pkg::NW'(dvre_pkg::NODES - 1)) begin
          q_next = '0;
          state_next = S_LAT;
        end
      end
      S_LAT: begin
        // issue the vector memory read of (q,d); the read data is registered
        cmd.clr_best = 1'b1;
        state_next = S_EVAL;
        q_next = q + 1'b1;
      end
      S_EVAL: begin
        // compare the neighbour read last cycle while reading the next one
        cmd.eval = 1'b1;
        if (q == '0) begin
          state_next = S_EMIT;
        end else begin
          q_next = q + 1'b1;
        end
      end
      S_EMIT: begin
        if (room) begin
          cmd.emit = 1'b1;
          q_next = '0;
          if (d == dvre_pkg::NW'(dvre_pkg::NODES - 1)) begin
            d_next = '0;
            state_next = S_IDLE;
          end else begin
            d_next = d + 1'b1;
            state_next = S_LAT;
          end
        end
      end
      S_STATUS: begin
        if (room) begin
          cmd.emit_status = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      q <= '0;
      d <= '0;
    end else begin
      state <= state_next;
      q <= q_next;
      d <= d_next;
    end
  end

  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit && cmd.emit_status)) else $error("double emit");
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.emit_status) |-> room) else $error("emit without room");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_item |=> state == S_DECIDE) else $error("load not followed by decide");
endmodule
`default_nettype wire

// ----- design/dvre_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dvre_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire dvre_pkg::in_item_t in_item,
  input  wire dvre_pkg::dp_cmd_t cmd,
  output dvre_pkg::dp_stat_t stat,
  input  wire logic out_take,
  output logic out_full,
  output dvre_pkg::out_item_t out_item
);
  localparam int NODES = dvre_pkg::NODES;
  localparam int NW = dvre_pkg::NW;
  localparam int CW = dvre_pkg::CW;

  logic [3:0] self_id;
  logic [NODES-1:0] mask;
  logic [CW-1:0] link_cost [NODES];
  logic [NODES-1:0] disabled;
  logic [2:0] alive [NODES];
  logic [CW-1:0] vmem [dvre_pkg::VDEPTH];
  logic [NODES-1:0] vwritten [NODES];
  logic [CW-1:0] vrd;
  logic vrd_ok;
  logic [NW-1:0] vrd_q, vrd_d;
  dvre_pkg::in_item_t item;
  logic item_ok_q;
  logic [CW-1:0] best;
  logic [3:0] hop;
  logic [NODES-1:0] active;
  logic node_ok, dest_ok;
  logic [NW-1:0] nidx, didx;
  logic [CW:0] sum;
  logic [CW-1:0] rep, sat;

  always_comb begin
    for (int i = 0; i < NODES; i++)
      active[i] = mask[i] && !disabled[i] && (self_id != 4'(i + 1)) && (i < 8);
  end

  assign nidx = NW'(item.node_id - 4'd1);
  assign didx = NW'(item.dest_id - 4'd1);
  assign node_ok = item.node_id >= 4'd1 && {1'b0, item.node_id} <= 5'(NODES)
                   && active[nidx];
  assign dest_ok = item.dest_id >= 4'd1 && {1'b0, item.dest_id} <= 5'(NODES);
  assign stat.operation = item.operation;
  assign stat.last = item.last;
  assign stat.item_ok = node_ok &&
                        (item.operation != dvre_pkg::OP_ENTRY || dest_ok);

  always_ff @(posedge clk) begin
    if (cmd.load_item) item <= in_item;
  end

  // verdict kept from before the update, a disable clears its own target
  always_ff @(posedge clk) begin
    if (cmd.apply_item) item_ok_q <= stat.item_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      self_id <= 4'd1;
      mask <= '0;
    end else if (cfg_we) begin
      if (cfg_index == dvre_pkg::CFG_SELF_ID) self_id <= cfg_data[3:0];
      else mask <= NODES'(cfg_data);
    end
  end

  // vector memory: written entries tracked per row, otherwise diagonal default
  always_ff @(posedge clk) begin
    if (cmd.apply_item && stat.item_ok && item.operation == dvre_pkg::OP_ENTRY)
      vmem[{nidx, didx}] <= item.cost;
    vrd <= vmem[{cmd.q, cmd.d}];
    vrd_q <= cmd.q;
    vrd_d <= cmd.d;
    vrd_ok <= vwritten[cmd.q][cmd.d];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NODES; i++) begin
        link_cost[i] <= dvre_pkg::INF_COST;
        alive[i] <= '0;
        vwritten[i] <= '0;
      end
      disabled <= '0;
    end else begin
      if (cmd.apply_item && stat.item_ok) begin
        case (item.operation)
          dvre_pkg::OP_ENTRY: begin
            vwritten[nidx][didx] <= 1'b1;
            alive[nidx] <= '0;
          end
          dvre_pkg::OP_COST: link_cost[nidx] <= item.cost;
          dvre_pkg::OP_DISABLE: disabled[nidx] <= 1'b1;
          default: ;
        endcase
      end
      if (cmd.tick_step && active[cmd.q]) begin
        if (alive[cmd.q] < dvre_pkg::COUNT_MAX) alive[cmd.q] <= alive[cmd.q] + 3'd1;
        if (alive[cmd.q] == dvre_pkg::DEAD_COUNT - 3'd1)
          link_cost[cmd.q] <= dvre_pkg::INF_COST;
      end
    end
  end

  // one adder and one compare per cycle
  assign rep = vrd_ok ? vrd : ((vrd_q == vrd_d) ? '0 : dvre_pkg::INF_COST);
  assign sum = {1'b0, link_cost[vrd_q]} + {1'b0, rep};
  assign sat = sum[CW] ? dvre_pkg::INF_COST : sum[CW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.clr_best) begin
      best <= dvre_pkg::INF_COST;
      hop <= '0;
    end else if (cmd.eval && active[vrd_q] && sat < best) begin
      best <= sat;
      hop <= 4'(vrd_q) + 4'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_full <= 1'b0;
    else if (cmd.emit || cmd.emit_status) out_full <= 1'b1;
    else if (out_take) out_full <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.status <= 1'b0;
      out_item.dest_id_res <= 4'(cmd.d) + 4'd1;
      out_item.route_cost <= (self_id == 4'(cmd.d) + 4'd1) ? '0 : best;
      out_item.next_hop <= (self_id == 4'(cmd.d) + 4'd1) ? '0 : hop;
      out_item.last_res <= (cmd.d == NW'(NODES - 1));
    end else if (cmd.emit_status) begin
      out_item.status <= !item_ok_q;
      out_item.dest_id_res <= '0;
      out_item.route_cost <= '0;
      out_item.next_hop <= '0;
      out_item.last_res <= 1'b1;
    end
  end

  a_hop_range: assert property (@(posedge clk) disable iff (rst)
    out_full |-> out_item.next_hop <= 4'(NODES)) else $error("hop out of range");
  a_inf_nohop: assert property (@(posedge clk) disable iff (rst)
    (out_full && !out_item.status && out_item.route_cost == dvre_pkg::INF_COST)
    |-> out_item.next_hop == '0) else $error("hop on unreachable route");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_full && !out_take) |=> out_full) else $error("result dropped");
endmodule
`default_nettype wire

// ----- design/distance_vector_route_engine_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel | direction | handshake           | payload
// in      | into      | in_valid / in_stall   | in_data (in_item_t)
// out     | out of    | out_valid / out_stall | out_data (out_item_t)
// cfg     | into      | cfg_we                | cfg_index, cfg_data
// status-only items emit one status beat; recompute items run, for each destination,
// a memory read, a compare per neighbour and an emit, after a tick's ageing sweep
// the recompute loop is set by one adder and comparator reading the vector memory
// rst is synchronous; the vector memory keeps per-entry written bits, no clear pass
// out_stall holds the result register and pauses the walk; one item at a time
module distance_vector_route_engine_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire dvre_pkg::in_item_t in_data,
  output logic out_valid,
  input  wire logic out_stall,
  output dvre_pkg::out_item_t out_data
);
  dvre_pkg::dp_cmd_t cmd;
  dvre_pkg::dp_stat_t stat;
  logic out_full;

  // result beat leaves when not stalled
  assign out_valid = out_full;

  dvre_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_full(out_full), .out_take(!out_stall), .stat(stat), .cmd(cmd)
  );

  dvre_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_item(in_data), .cmd(cmd), .stat(stat),
    .out_take(!out_stall), .out_full(out_full), .out_item(out_data)
  );
endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  // clock, reset and block ports
  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [7:0] cfg_data;
  logic in_valid;
  logic in_stall;
  dvre_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  dvre_pkg::out_item_t out_data;

  distance_vector_route_engine_top u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // predictor state, a copy of what the block should hold
  logic [3:0] node_self;
  logic [7:0] link_mask;
  logic [15:0] hop_cost [8];
  logic node_off [8];
  logic [2:0] silence [8];
  logic [15:0] heard [8][8];

  dvre_pkg::in_item_t pending_beats[$];
  dvre_pkg::out_item_t route_expect[$];
  int mismatches;
  bit in_taken;
  int burst_left;
  int gap_left;
  int stall_mode;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit is_peer(input logic [3:0] id);
    if (id < 1 || id > 8 || id == node_self) return 1'b0;
    if (!link_mask[id-1]) return 1'b0;
    return !node_off[id-1];
  endfunction

  task automatic push_status(input logic st);
    dvre_pkg::out_item_t r;
    r = '0;
    r.status = st;
    r.last_res = 1'b1;
    route_expect.push_back(r);
  endtask

  // recompute the whole table; one beat per destination
  task automatic push_table();
    dvre_pkg::out_item_t r;
    logic [16:0] sum;
    logic [15:0] best;
    logic [3:0] hop;
    for (int d = 1; d <= 8; d++) begin
      best = 16'hFFFF;
      hop = '0;
      if (d == node_self) begin
        best = '0;
      end else begin
        for (int q = 1; q <= 8; q++) begin
          if (is_peer(q[3:0])) begin
            sum = hop_cost[q-1] + heard[q-1][d-1];
            if (sum > 17'hFFFF) sum = 17'hFFFF;
            if (sum[15:0] < best) begin
              best = sum[15:0];
              hop = q[3:0];
            end
          end
        end
      end
      r.status = 1'b0;
      r.dest_id_res = d[3:0];
      r.route_cost = best;
      r.next_hop = hop;
      r.last_res = (d == 8);
      route_expect.push_back(r);
    end
  endtask

  task automatic predict_routes(input dvre_pkg::in_item_t it);
    case (it.operation)
      dvre_pkg::OP_ENTRY: begin
        if (!is_peer(it.node_id) || it.dest_id < 1 || it.dest_id > 8) begin
          push_status(1'b1);
        end else begin
          heard[it.node_id-1][it.dest_id-1] = it.cost;
          silence[it.node_id-1] = '0;
          if (it.last) push_table();
          else push_status(1'b0);
        end
      end
      dvre_pkg::OP_COST: begin
        if (!is_peer(it.node_id)) begin
          push_status(1'b1);
        end else begin
          hop_cost[it.node_id-1] = it.cost;
          push_table();
        end
      end
      dvre_pkg::OP_DISABLE: begin
        if (!is_peer(it.node_id)) begin
          push_status(1'b1);
        end else begin
          node_off[it.node_id-1] = 1'b1;
          push_status(1'b0);
        end
      end
      default: begin
        for (int q = 1; q <= 8; q++) begin
          if (is_peer(q[3:0])) begin
            if (silence[q-1] < dvre_pkg::COUNT_MAX) silence[q-1]++;
            if (silence[q-1] == dvre_pkg::DEAD_COUNT) hop_cost[q-1] = 16'hFFFF;
          end
        end
        push_table();
      end
    endcase
  endtask

  function automatic dvre_pkg::in_item_t make_beat(input logic [1:0] op,
                                                   input logic [3:0] node,
                                                   input logic [3:0] dst,
                                                   input logic [15:0] c,
                                                   input logic lst);
    dvre_pkg::in_item_t it;
    it.operation = op;
    it.node_id = node;
    it.dest_id = dst;
    it.cost = c;
    it.last = lst;
    return it;
  endfunction

  function automatic logic [15:0] rand_cost();
    case ($urandom_range(0, 5))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return 16'($urandom_range(16'hFF00, 16'hFFFF));
      default: return 16'($urandom_range(0, 200));
    endcase
  endfunction

  // sender: bursts with random gaps, a beat is held until it is taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        in_data <= pending_beats.pop_front();
        in_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 8);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, changes mode now and then
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 150) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // accepted input beats feed the predictor
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) predict_routes(in_data);
  end

  // result checker
  always @(posedge clk) begin
    dvre_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (route_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = route_expect.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, out_data);
        end
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == dvre_pkg::CFG_SELF_ID) node_self = val[3:0];
    else link_mask = val;
  endtask

  // let everything queued drain, then a pause for status-only tails
  task automatic drain();
    wait (pending_beats.size() == 0);
    @(posedge clk);
    while (in_valid || route_expect.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // well-formed vectors from peers, with cost changes, ticks, disables and noise
  task automatic random_phase(input int count);
    int n;
    logic [3:0] peer;
    logic [1:0] op;
    n = 0;
    while (n < count) begin
      peer = 4'($urandom_range(1, 8));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          for (int d = 1; d <= 8; d++) begin
            pending_beats.push_back(make_beat(dvre_pkg::OP_ENTRY, peer, d[3:0],
                                              rand_cost(), d == 8));
            n++;
          end
        end
        4, 5: begin
          pending_beats.push_back(make_beat(dvre_pkg::OP_COST, peer, 4'($urandom),
                                            rand_cost(), 1'($urandom)));
          n++;
        end
        6: begin
          pending_beats.push_back(make_beat(dvre_pkg::OP_TICK, 4'($urandom), 4'($urandom),
                                            16'($urandom), 1'($urandom)));
          n++;
        end
        7: begin
          if ($urandom_range(0, 3) == 0)
            pending_beats.push_back(make_beat(dvre_pkg::OP_DISABLE, peer, 4'($urandom),
                                              16'($urandom), 1'($urandom)));
          else
            pending_beats.push_back(make_beat(dvre_pkg::OP_ENTRY, peer,
                                              4'($urandom_range(1, 8)), rand_cost(), 1'b1));
          n++;
        end
        default: begin
          op = 2'($urandom);
          pending_beats.push_back(make_beat(op, 4'($urandom), 4'($urandom),
                                            16'($urandom), 1'($urandom)));
          n++;
        end
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = dvre_pkg::CFG_SELF_ID;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    mismatches = 0;
    node_self = 4'd1;
    link_mask = '0;
    for (int i = 0; i < 8; i++) begin
      hop_cost[i] = 16'hFFFF;
      node_off[i] = 1'b0;
      silence[i] = '0;
      for (int j = 0; j < 8; j++) heard[i][j] = (i == j) ? 16'h0 : 16'hFFFF;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset config: no neighbours, every target inactive
    pending_beats.push_back(make_beat(dvre_pkg::OP_ENTRY, 4'd2, 4'd3, 16'd5, 1'b1));
    pending_beats.push_back(make_beat(dvre_pkg::OP_COST, 4'd2, 4'd0, 16'd5, 1'b0));
    pending_beats.push_back(make_beat(dvre_pkg::OP_TICK, 4'd15, 4'd15, 16'hFFFF, 1'b1));
    drain();

    write_reg(dvre_pkg::CFG_SELF_ID, 8'd3);
    write_reg(dvre_pkg::CFG_MASK, 8'hFF);
    // directed: costs, entries, saturation, ties, bad ids, self target, ticks, disables
    pending_beats.push_back(make_beat(dvre_pkg::OP_COST, 4'd1, 4'd0, 16'd10, 1'b0));
    pending_beats.push_back(make_beat(dvre_pkg::OP_COST, 4'd2, 4'd0, 16'd10, 1'b0));
    pending_beats.push_back(make_beat(dvre_pkg::OP_COST, 4'd8, 4'd0, 16'hFFFE, 1'b0));
    pending_beats.push_back(make_beat(dvre_pkg::OP_ENTRY, 4'd1, 4'd5, 16'd7, 1'b0));
    pending_beats.push_back(make_beat(dvre_pkg::OP_ENTRY, 4'd2, 4'd5, 16'd7, 1'b1));
    pending_beats.push_back(make_beat(dvre_pkg::OP_ENTRY, 4'd8, 4'd6, 16'hFFFF, 1'b1));
    pending_beats.push_back(make_beat(dvre_pkg::OP_ENTRY, 4'd8, 4'd7, 16'd1, 1'b1));
    pending_beats.push_back(make_beat(dvre_pkg::OP_ENTRY, 4'd1, 4'd0, 16'd1, 1'b0));
    pending_beats.push_back(make_beat(dvre_pkg::OP_ENTRY, 4'd1, 4'd9, 16'd1, 1'b1));
    pending_beats.push_back(make_beat(dvre_pkg::OP_ENTRY, 4'd3, 4'd2, 16'd1, 1'b1));
    pending_beats.push_back(make_beat(dvre_pkg::OP_COST, 4'd0, 4'd0, 16'd1, 1'b0));
    pending_beats.push_back(make_beat(dvre_pkg::OP_COST, 4'd15, 4'd0, 16'd1, 1'b0));
    for (int k = 0; k < 5; k++)
      pending_beats.push_back(make_beat(dvre_pkg::OP_TICK, 4'd0, 4'd0, 16'd0, 1'b0));
    pending_beats.push_back(make_beat(dvre_pkg::OP_DISABLE, 4'd2, 4'd0, 16'd0, 1'b0));
    pending_beats.push_back(make_beat(dvre_pkg::OP_DISABLE, 4'd2, 4'd0, 16'd0, 1'b0));
    pending_beats.push_back(make_beat(dvre_pkg::OP_COST, 4'd1, 4'd0, 16'd0, 1'b1));
    drain();

    // random phases over several configurations, including extremes
    write_reg(dvre_pkg::CFG_SELF_ID, 8'd8);
    write_reg(dvre_pkg::CFG_MASK, 8'h7F);
    random_phase(90);
    drain();
    write_reg(dvre_pkg::CFG_SELF_ID, 8'd0);
    write_reg(dvre_pkg::CFG_MASK, 8'hA5);
    random_phase(80);
    drain();
    write_reg(dvre_pkg::CFG_SELF_ID, 8'd15);
    write_reg(dvre_pkg::CFG_MASK, 8'h5A);
    random_phase(80);
    drain();
    write_reg(dvre_pkg::CFG_SELF_ID, 8'd1);
    write_reg(dvre_pkg::CFG_MASK, 8'hFF);
    random_phase(80);
    drain();

    if (mismatches == 0 && route_expect.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

// ----- distance_vector_route_engine_top.f -----
design/dvre_pkg.sv
design/dvre_ctrl.sv
design/dvre_datapath.sv
design/distance_vector_route_engine_top.sv
sim/testbench.sv
